@@ rtl/assert_macros.svh @@
// Assertion macros used by the back end RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define GAE_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
`define GAE_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define GAE_ASSERT(lbl, prop, msg)
`define GAE_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

@@ rtl/gae_pkg.sv @@
// Types and constants of the grouped aggregation engine.
package gae_pkg;
	localparam int MAX_GROUPS = 1024;
	localparam int GRP_W = $clog2(MAX_GROUPS);
	localparam int CNT_W = 32;
	localparam int VAL_W = 64;

	typedef enum logic [1:0] {
		ACT_ACC = 2'd0,
		ACT_READ = 2'd1,
		ACT_CLEAR = 2'd2
	} action_t;

	typedef enum logic [2:0] {
		MODE_SUM = 3'd0,
		MODE_MEAN = 3'd1,
		MODE_COUNT = 3'd2,
		MODE_MIN = 3'd3,
		MODE_MAX = 3'd4,
		MODE_FIRST = 3'd5,
		MODE_LAST = 3'd6
	} agg_mode_t;

	typedef enum logic [1:0] {
		CFG_MODE = 2'd0,
		CFG_SIGNED = 2'd1,
		CFG_GROUPS = 2'd2
	} cfg_idx_t;

	typedef enum logic [1:0] {
		OP_ACC,
		OP_READ,
		OP_READ_ZERO,
		OP_CLEAR
	} op_t;

	typedef enum logic [2:0] {
		ST_SWEEP,
		ST_IDLE,
		ST_EXEC,
		ST_RESP
	} state_t;

	typedef struct packed {
		logic [1:0] action;
		logic [9:0] group;
		logic signed [63:0] row_value;
		logic value_missing;
	} in_beat_t;

	typedef struct packed {
		logic signed [63:0] result_value;
		logic [31:0] nonmiss_count;
		logic result_valid;
		logic result_missing;
	} out_beat_t;

	typedef struct packed {
		op_t op;
		logic [GRP_W-1:0] group;
		logic [VAL_W-1:0] value;
		logic missing;
	} work_t;

	typedef struct packed {
		logic seen;
		logic missing;
		logic [CNT_W-1:0] count;
		logic [VAL_W-1:0] value;
	} entry_t;

	typedef struct packed {
		agg_mode_t mode;
		logic signed_values;
	} back_cfg_t;
endpackage

@@ rtl/gae_front.sv @@
// Front end: accepts beats, classifies them and queues the work.
module gae_front import gae_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_stall,
	input  in_beat_t in_data,
	input  logic [10:0] groups_in_use,
	output logic q_valid,
	output work_t q_item,
	input  logic q_pop
);
	work_t fifo_q [2];
	logic wr_ptr_q, rd_ptr_q;
	logic [1:0] count_q;
	work_t cls;
	logic keep, push;
	logic in_range;

	// classify the incoming beat
	always_comb begin
		in_range = ({1'b0, in_data.group} < groups_in_use) &&
			(32'(in_data.group) < 32'(MAX_GROUPS));
		cls.group = GRP_W'(in_data.group);
		cls.value = in_data.row_value;
		cls.missing = in_data.value_missing;
		cls.op = OP_ACC;
		keep = 1'b0;
		case (in_data.action)
			ACT_ACC: begin
				cls.op = OP_ACC;
				keep = in_range;
			end
			ACT_READ: begin
				cls.op = in_range ? OP_READ : OP_READ_ZERO;
				keep = 1'b1;
			end
			ACT_CLEAR: begin
				cls.op = OP_CLEAR;
				keep = 1'b1;
			end
			default: keep = 1'b0;
		endcase
	end

	assign in_stall = (count_q == 2'd2);
	assign push = in_valid && !in_stall && keep;
	assign q_valid = (count_q != 2'd0);
	assign q_item = fifo_q[rd_ptr_q];

	// store queued work
	always_ff @(posedge clk) begin
		if (push) fifo_q[wr_ptr_q] <= cls;
	end

	// advance pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= !wr_ptr_q;
			if (q_pop) rd_ptr_q <= !rd_ptr_q;
			count_q <= count_q + 2'(push) - 2'(q_pop);
		end
	end
endmodule

@@ rtl/gae_back.sv @@
// Back end: group table, read-modify-write sequencer and result register.
`include "assert_macros.svh"
module gae_back import gae_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  back_cfg_t cfg,
	input  logic q_valid,
	input  work_t q_item,
	output logic q_pop,
	output logic out_valid,
	input  logic out_stall,
	output out_beat_t out_data
);
	entry_t mem [MAX_GROUPS];
	entry_t rd_q;
	work_t item_q;
	state_t state_q, state_d;
	logic [GRP_W-1:0] sweep_q;
	logic sweep_last;
	out_beat_t res_q, res_d;
	logic out_valid_q, load_out;
	entry_t base, upd;
	logic fresh, lt_new, lt_old;
	logic [VAL_W-1:0] va, vb;
	logic mem_we;
	logic [GRP_W-1:0] mem_waddr;
	entry_t mem_wdata;

	assign sweep_last = (sweep_q == GRP_W'(MAX_GROUPS - 1));
	assign load_out = (state_q == ST_RESP) && (!out_valid_q || !out_stall);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_SWEEP: if (sweep_last) state_d = ST_IDLE;
			ST_IDLE: begin
				if (q_valid) begin
					unique case (q_item.op)
						OP_CLEAR: state_d = ST_SWEEP;
						OP_READ_ZERO: state_d = ST_RESP;
						default: state_d = ST_EXEC;
					endcase
				end
			end
			ST_EXEC: state_d = (item_q.op == OP_READ) ? ST_RESP : ST_IDLE;
			ST_RESP: if (load_out) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	// outputs of the sequencer
	always_comb begin
		q_pop = (state_q == ST_IDLE) && q_valid;
	end

	// compute updated entry for an accumulated row
	always_comb begin
		fresh = !rd_q.seen;
		base = rd_q;
		if (fresh) begin
			base.seen = 1'b1;
			base.missing = 1'b0;
			base.count = '0;
			base.value = '0;
		end
		va = item_q.value ^ {cfg.signed_values, {(VAL_W-1){1'b0}}};
		vb = rd_q.value ^ {cfg.signed_values, {(VAL_W-1){1'b0}}};
		lt_new = va < vb;
		lt_old = vb < va;
		upd = rd_q;
		case (cfg.mode)
			MODE_SUM, MODE_MEAN, MODE_COUNT: begin
				if (!item_q.missing) begin
					upd = base;
					if (cfg.mode != MODE_COUNT) upd.value = base.value + item_q.value;
				end
			end
			MODE_MIN, MODE_MAX, MODE_FIRST: begin
				upd = base;
				if (fresh || rd_q.missing) begin
					upd.value = item_q.missing ? '0 : item_q.value;
					upd.missing = item_q.missing;
				end else if (!item_q.missing && cfg.mode == MODE_MIN) begin
					if (lt_new) upd.value = item_q.value;
				end else if (!item_q.missing && cfg.mode == MODE_MAX) begin
					if (lt_old) upd.value = item_q.value;
				end
			end
			MODE_LAST: begin
				upd = base;
				if (fresh || !item_q.missing) begin
					upd.value = item_q.missing ? '0 : item_q.value;
					upd.missing = item_q.missing;
				end
			end
			default: upd = rd_q;
		endcase
		if (cfg.mode <= MODE_LAST && !item_q.missing && upd.count != '1)
			upd.count = upd.count + 1'b1;
	end

	// build the read result
	always_comb begin
		res_d = '0;
		if (state_q == ST_EXEC && item_q.op == OP_READ) begin
			if (rd_q.seen) begin
				res_d.result_value = (rd_q.missing || cfg.mode == MODE_COUNT) ? '0 :
					rd_q.value;
				res_d.nonmiss_count = rd_q.count;
				res_d.result_valid = 1'b1;
				res_d.result_missing = rd_q.missing;
			end else begin
				res_d.result_valid = (cfg.mode == MODE_SUM);
			end
		end
	end

	// select the table write
	always_comb begin
		mem_we = 1'b0;
		mem_waddr = item_q.group;
		mem_wdata = upd;
		if (state_q == ST_SWEEP) begin
			mem_we = 1'b1;
			mem_waddr = sweep_q;
			mem_wdata = '0;
		end else if (state_q == ST_EXEC && item_q.op == OP_ACC) begin
			mem_we = 1'b1;
		end
	end

	// group table
	always_ff @(posedge clk) begin
		if (mem_we) mem[mem_waddr] <= mem_wdata;
		if (q_pop) rd_q <= mem[q_item.group];
	end

	// hold the popped item and the pending result
	always_ff @(posedge clk) begin
		if (q_pop) item_q <= q_item;
		if (state_q == ST_EXEC) res_q <= res_d;
		else if (state_q == ST_IDLE) res_q <= '0;
		if (load_out) out_data <= res_q;
	end

	// sequencer state, sweep pointer and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_SWEEP;
			sweep_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_SWEEP) sweep_q <= sweep_q + 1'b1;
			else sweep_q <= '0;
			if (load_out) out_valid_q <= 1'b1;
			else if (!out_stall) out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;

	`GAE_ASSERT(a_pop_idle, q_pop |-> (state_q == ST_IDLE), "pop outside idle")
	`GAE_ASSERT(a_out_from_resp, $rose(out_valid_q) |-> $past(state_q == ST_RESP), "result not from response state")
	`GAE_ASSERT(a_exec_after_idle, (state_q == ST_EXEC) |-> $past(state_q == ST_IDLE), "exec without lookup")
endmodule

@@ rtl/grouped_aggregation_engine.sv @@
// Grouped aggregation engine top level: configuration registers and the two halves.
//
// Input channel in_valid/in_stall/in_data carries one beat per action: accumulate a
// row, read one group, or clear all groups. Output channel out_valid/out_stall/out_data
// carries one beat per read. The configuration port writes agg_mode, signed_values and
// groups_in_use by cfg_index; the user must write them only while the block is idle,
// as the block does not enforce it. A two-entry queue parts the front classifier from
// the back sequencer. The back takes one queued item at a time: an accumulate reads
// the table in the idle state and writes it in the exec state; a read passes idle,
// exec and response, which loads the output register. Out-of-range reads skip exec;
// dropped rows never enter the queue. Throughput is set by the single-port
// read-modify-write of the group table. A clear action sweeps the table, one group per
// cycle, over all 1024 groups; after reset the same sweep runs, and the queue fills
// and then stalls. A stalled output holds its beat; the back holds the next result
// until it is taken, and the queue stalls the input once it is full.
module grouped_aggregation_engine import gae_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_stall,
	input  in_beat_t in_data,
	output logic out_valid,
	input  logic out_stall,
	output out_beat_t out_data,
	input  logic cfg_we,
	input  logic [1:0] cfg_index,
	input  logic [10:0] cfg_data
);
	agg_mode_t mode_q;
	logic signed_q;
	logic [10:0] groups_q;
	back_cfg_t bcfg;
	logic q_valid, q_pop;
	work_t q_item;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_SUM;
			signed_q <= 1'b1;
			groups_q <= 11'd1024;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_MODE: mode_q <= agg_mode_t'(cfg_data[2:0]);
				CFG_SIGNED: signed_q <= cfg_data[0];
				CFG_GROUPS: groups_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign bcfg.mode = mode_q;
	assign bcfg.signed_values = signed_q;

	gae_front u_front (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
		.in_data(in_data), .groups_in_use(groups_q), .q_valid(q_valid),
		.q_item(q_item), .q_pop(q_pop)
	);

	gae_back u_back (
		.clk(clk), .arst_n(arst_n), .cfg(bcfg), .q_valid(q_valid), .q_item(q_item),
		.q_pop(q_pop), .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
	);
endmodule
